// ----- hdl/cgdz_pkg.sv -----
// Package for the color gradient block: widths, state types, queue payload
// and the per-channel Prewitt sum. No dependencies.
`timescale 1ns / 1ps
package cgdz_pkg;

  localparam int LWW     = 12;   // line_width register width
  localparam int FHW     = 13;   // frame_height register width
  localparam int CFGW    = 13;   // configuration data width
  localparam int CFGIW   = 1;    // configuration index width
  localparam int ROWW    = 12;   // row counter width
  localparam int FH_MAX  = 4096;
  localparam int PXW     = 24;
  localparam int GW      = 11;   // one channel gradient, signed
  localparam int AW      = 22;   // gxx, gyy, gxy accumulators
  localparam int D4W     = 47;   // 4 * d
  localparam int SQW     = 48;   // square root operand
  localparam int SQSTEPS = 24;
  localparam int SQCW    = 5;
  localparam int REMW    = 28;
  localparam int RTW     = 24;
  localparam int MAGW    = 11;
  localparam int MAG_MAX = 1397;
  localparam int QDEPTH  = 2;

  localparam logic [CFGIW-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFGIW-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE, F_RD, F_WIN, F_MAC, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SQ1, B_SQ2, B_OUT
  } back_state_e;

  typedef struct packed {
    logic [AW-1:0]        s;
    logic signed [AW-1:0] dd;
    logic signed [AW-1:0] gxy;
    logic                 dir;
    logic                 last;
  } grad_t;

  // Sum of three positive taps minus three negative taps of one channel.
  function automatic logic signed [GW-1:0] prewitt(
    input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2,
    input logic [7:0] n0, input logic [7:0] n1, input logic [7:0] n2);
    return $signed({3'b000, p0}) + $signed({3'b000, p1}) + $signed({3'b000, p2})
         - $signed({3'b000, n0}) - $signed({3'b000, n1}) - $signed({3'b000, n2});
  endfunction

endpackage

// ----- hdl/cgdz_if.sv -----
// Stream interfaces of the color gradient block: pixel beats in, result
// beats out. Uses the cgdz_pkg widths.
`timescale 1ns / 1ps
interface cgdz_pix_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] lum;
  logic [7:0] chroma_a;
  logic [7:0] chroma_b;
  modport source (output valid, frame_start, lum, chroma_a, chroma_b, input ready);
  modport sink (input valid, frame_start, lum, chroma_a, chroma_b, output ready);
endinterface

interface cgdz_res_if;
  logic                       valid;
  logic                       ready;
  logic [cgdz_pkg::MAGW-1:0]  magnitude;
  logic                       direction;
  logic                       last_of_frame;
  modport source (output valid, magnitude, direction, last_of_frame, input ready);
  modport sink (input valid, magnitude, direction, last_of_frame, output ready);
endinterface

// ----- hdl/cgdz_front.sv -----
// Front of the gradient block: position counters, line stores, 3x3 window
// and gxx/gyy/gxy accumulation. Depends on cgdz_pkg and cgdz_if.
`timescale 1ns / 1ps
module cgdz_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cgdz_pkg::LWW-1:0]  line_width_i,
  input  logic [cgdz_pkg::FHW-1:0]  frame_height_i,
  cgdz_pix_if.sink                  pix,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output cgdz_pkg::grad_t           q_data_o
);
  import cgdz_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int GEW = (CW + 1 > FHW) ? CW + 1 : FHW;

  front_state_e state_q, state_d;

  logic [GEW-1:0]  w_eff, h_eff, lw_ext, fh_ext, c_inc, r_inc;
  logic [CW-1:0]   col_q, cur_c;
  logic [ROWW-1:0] row_q, cur_r;
  logic            accept;

  logic [PXW-1:0]  win_q [6];
  logic [PXW-1:0]  px_q, up_rd_q, mid_rd_q;
  logic [CW-1:0]   c_q;
  logic            prod_q, last_q;
  logic [1:0]      k_q;
  logic signed [GW-1:0] gx_q [3];
  logic signed [GW-1:0] gy_q [3];
  logic signed [AW-1:0] gxx_q, gyy_q, gxy_q;
  logic signed [2*GW-1:0] sq_x, sq_y, pr_xy;

  logic [PXW-1:0] upper_mem  [MAX_WIDTH];
  logic [PXW-1:0] middle_mem [MAX_WIDTH];

  // Geometry as used: both registers clamped to their legal ranges.
  always_comb begin
    lw_ext = GEW'(line_width_i);
    fh_ext = GEW'(frame_height_i);
    if (lw_ext < GEW'(3)) begin
      w_eff = GEW'(3);
    end else if (lw_ext > GEW'(MAX_WIDTH)) begin
      w_eff = GEW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    if (fh_ext < GEW'(3)) begin
      h_eff = GEW'(3);
    end else if (fh_ext > GEW'(FH_MAX)) begin
      h_eff = GEW'(FH_MAX);
    end else begin
      h_eff = fh_ext;
    end
  end

  assign accept = pix.valid & pix.ready;
  assign cur_c  = pix.frame_start ? '0 : col_q;
  assign cur_r  = pix.frame_start ? '0 : row_q;
  assign c_inc  = GEW'(cur_c) + GEW'(1);
  assign r_inc  = GEW'(cur_r) + GEW'(1);

  always_comb begin
    state_d   = state_q;
    pix.ready = 1'b0;
    q_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        pix.ready = 1'b1;
        if (pix.valid) begin
          state_d = F_RD;
        end
      end
      F_RD: begin
        state_d = F_WIN;
      end
      F_WIN: begin
        state_d = prod_q ? F_MAC : F_IDLE;
      end
      F_MAC: begin
        if (k_q == 2'd2) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        q_valid_o = 1'b1;
        if (q_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (c_inc >= w_eff) begin
          col_q <= '0;
          row_q <= (r_inc >= h_eff) ? '0 : r_inc[ROWW-1:0];
        end else begin
          col_q <= c_inc[CW-1:0];
          row_q <= cur_r;
        end
      end
      if (state_q == F_WIN) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= up_rd_q;
        win_q[4] <= mid_rd_q;
        win_q[5] <= px_q;
      end
    end
  end

  // Line stores: read the cycle after the beat, written back in the window cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == F_RD) begin
      up_rd_q  <= upper_mem[c_q];
      mid_rd_q <= middle_mem[c_q];
    end
    if (state_q == F_WIN) begin
      upper_mem[c_q]  <= mid_rd_q;
      middle_mem[c_q] <= px_q;
    end
  end

  assign sq_x  = gx_q[k_q] * gx_q[k_q];
  assign sq_y  = gy_q[k_q] * gy_q[k_q];
  assign pr_xy = gx_q[k_q] * gy_q[k_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= {pix.chroma_b, pix.chroma_a, pix.lum};
      c_q    <= cur_c;
      prod_q <= (cur_r >= ROWW'(2)) && (cur_c >= CW'(2));
      last_q <= (GEW'(cur_r) == h_eff - GEW'(1)) && (GEW'(cur_c) == w_eff - GEW'(1));
    end
    if (state_q == F_WIN) begin
      for (int k = 0; k < 3; k++) begin
        gx_q[k] <= prewitt(up_rd_q[8*k +: 8], mid_rd_q[8*k +: 8], px_q[8*k +: 8],
                           win_q[0][8*k +: 8], win_q[1][8*k +: 8], win_q[2][8*k +: 8]);
        gy_q[k] <= prewitt(win_q[2][8*k +: 8], win_q[5][8*k +: 8], px_q[8*k +: 8],
                           win_q[0][8*k +: 8], win_q[3][8*k +: 8], up_rd_q[8*k +: 8]);
      end
      gxx_q <= '0;
      gyy_q <= '0;
      gxy_q <= '0;
      k_q   <= '0;
    end
    if (state_q == F_MAC) begin
      gxx_q <= gxx_q + AW'(sq_x);
      gyy_q <= gyy_q + AW'(sq_y);
      gxy_q <= gxy_q + AW'(pr_xy);
      k_q   <= k_q + 2'd1;
    end
  end

  always_comb begin
    q_data_o.s    = $unsigned(gxx_q + gyy_q);
    q_data_o.dd   = gxx_q - gyy_q;
    q_data_o.gxy  = gxy_q;
    q_data_o.dir  = !((gxx_q > gyy_q) || ((gxx_q == gyy_q) && (gxy_q == '0)));
    q_data_o.last = last_q;
  end

endmodule

// ----- hdl/cgdz_fifo.sv -----
// Short queue between the front and the back of the gradient block.
// Depends on cgdz_pkg.
`timescale 1ns / 1ps
module cgdz_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  cgdz_pkg::grad_t  push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output cgdz_pkg::grad_t  pop_data_o
);
  import cgdz_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  grad_t          mem_q [QDEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [NW-1:0]  cnt_q;
  logic           push, pop;

  assign push_ready_o = cnt_q != NW'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - NW'(1)))
    else $error("queue count did not drop on a lone pop");

endmodule

// ----- hdl/cgdz_back.sv -----
// Back of the gradient block: forms 4*d with three small multipliers and runs
// two integer square roots on a shared unit. Depends on cgdz_pkg, cgdz_if.
`timescale 1ns / 1ps
module cgdz_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  cgdz_pkg::grad_t  q_data_i,
  cgdz_res_if.source       res
);
  import cgdz_pkg::*;

  back_state_e state_q, state_d;

  logic [AW-1:0]    s_q;
  logic [20:0]      add_q, agxy_q, x;
  logic             dir_q, last_q;
  logic [2:0]       k_q;
  logic [D4W-1:0]   d4_q, d4_n, term;
  logic [9:0]       xh;
  logic [10:0]      xl;
  logic [21:0]      prod_hh, prod_hl, prod_ll;
  logic [SQW-1:0]   opnd_q;
  logic [REMW-1:0]  rem_q, rem_n, trial;
  logic [RTW-1:0]   root_q, root_n;
  logic [SQCW-1:0]  step_q;
  logic             sq_last;
  logic [24:0]      t_val;
  logic [13:0]      p1;
  logic [MAGW-1:0]  mag_q;
  logic signed [AW-1:0] neg_dd, neg_gxy;

  assign neg_dd  = -q_data_i.dd;
  assign neg_gxy = -q_data_i.gxy;

  // Partial products of |x|^2 with x split at bit 11.
  assign x       = (k_q < 3'd3) ? add_q : agxy_q;
  assign xh      = x[20:11];
  assign xl      = x[10:0];
  assign prod_hh = 22'(xh * xh);
  assign prod_hl = 22'(xh * xl);
  assign prod_ll = 22'(xl * xl);

  always_comb begin
    case (k_q)
      3'd0:    term = D4W'(prod_hh) << 24;
      3'd1:    term = D4W'(prod_hl) << 14;
      3'd2:    term = D4W'(prod_ll) << 2;
      3'd3:    term = D4W'(prod_hh) << 26;
      3'd4:    term = D4W'(prod_hl) << 16;
      default: term = D4W'(prod_ll) << 4;
    endcase
  end
  assign d4_n = d4_q + term;

  // One digit of the restoring square root per cycle.
  assign rem_n   = {rem_q[REMW-3:0], opnd_q[SQW-1 -: 2]};
  assign trial   = REMW'({root_q, 2'b01});
  assign root_n  = (rem_n >= trial) ? {root_q[RTW-2:0], 1'b1} : {root_q[RTW-2:0], 1'b0};
  assign sq_last = step_q == SQCW'(SQSTEPS - 1);
  assign t_val   = {2'b00, s_q, 1'b0} + 25'(root_n);
  assign p1      = 14'(root_n[12:0]) + 14'd1;

  always_comb begin
    state_d   = state_q;
    q_ready_o = 1'b0;
    res.valid = 1'b0;
    case (state_q)
      B_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        if (k_q == 3'd5) begin
          state_d = B_SQ1;
        end
      end
      B_SQ1: begin
        if (sq_last) begin
          state_d = B_SQ2;
        end
      end
      B_SQ2: begin
        if (sq_last) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        res.valid = 1'b1;
        if (res.ready) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        s_q    <= q_data_i.s;
        add_q  <= q_data_i.dd[AW-1] ? neg_dd[20:0] : q_data_i.dd[20:0];
        agxy_q <= q_data_i.gxy[AW-1] ? neg_gxy[20:0] : q_data_i.gxy[20:0];
        dir_q  <= q_data_i.dir;
        last_q <= q_data_i.last;
        d4_q   <= '0;
        k_q    <= '0;
      end
      B_MUL: begin
        d4_q   <= d4_n;
        k_q    <= k_q + 3'd1;
        opnd_q <= SQW'(d4_n);
        rem_q  <= '0;
        root_q <= '0;
        step_q <= '0;
      end
      B_SQ1, B_SQ2: begin
        if (sq_last) begin
          opnd_q <= SQW'(t_val);
          rem_q  <= '0;
          root_q <= '0;
          step_q <= '0;
          mag_q  <= (p1[13:1] > 13'd2047) ? MAGW'(2047) : p1[MAGW:1];
        end else begin
          opnd_q <= {opnd_q[SQW-3:0], 2'b00};
          rem_q  <= (rem_n >= trial) ? rem_n - trial : rem_n;
          root_q <= root_n;
          step_q <= step_q + SQCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign res.magnitude     = mag_q;
  assign res.direction     = dir_q;
  assign res.last_of_frame = last_q;

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (res.magnitude <= MAGW'(MAG_MAX)))
    else $error("gradient magnitude out of range");

endmodule

// ----- hdl/color_gradient_di_zenzo.sv -----
// Top level of the Di Zenzo color gradient block: configuration registers,
// front, queue and back. Depends on cgdz_pkg, cgdz_if and the cgdz modules.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake        Payload
//  pix_i     in         valid / ready    frame_start, lum, chroma_a, chroma_b
//  res_o     out        valid / ready    magnitude, direction, last_of_frame
//  cfg       in         cfg_we_i         cfg_idx_i, cfg_data_i (write only)
//
// A pixel beat passes through the front states idle, read and window; an
// interior pixel adds the multiply-accumulate over the three channels and
// the queue push, which waits while the queue is full. The back takes one
// result at a time: the six-step multiplier that forms 4*d, the shared
// square root unit (two roots of 24 digit steps), then the res_o handshake.
// Reset clears the counters, the window and all control; the line stores
// hold no reset; only values written in this frame feed a gradient.
// The two-entry queue lets the front keep taking pixels while the back works
// or while a result waits on res_o.
module color_gradient_di_zenzo #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cgdz_pkg::CFGIW-1:0]  cfg_idx_i,
  input  logic [cgdz_pkg::CFGW-1:0]   cfg_data_i,
  cgdz_pix_if.sink                    pix_i,
  cgdz_res_if.source                  res_o
);
  import cgdz_pkg::*;

  logic [LWW-1:0] line_width_q;
  logic [FHW-1:0] frame_height_q;

  logic  fq_valid, fq_ready, bq_valid, bq_ready;
  grad_t fq_data, bq_data;

  // Configuration must be written only while the block is idle (the block
  // does not enforce it), so the registers feed the front directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LWW'(640);
      frame_height_q <= FHW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_WIDTH:   line_width_q   <= cfg_data_i[LWW-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FHW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front tracks position, keeps the line stores and window, and sums
  // the three channel products for each interior pixel.
  cgdz_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .pix            (pix_i),
    .q_valid_o      (fq_valid),
    .q_ready_i      (fq_ready),
    .q_data_o       (fq_data)
  );

  cgdz_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_data)
  );

  // The back turns s, gxx-gyy and gxy into the rounded magnitude exactly:
  // q = isqrt(4d), then magnitude = (isqrt(2s + q) + 1) / 2.
  cgdz_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (bq_valid),
    .q_ready_o (bq_ready),
    .q_data_i  (bq_data),
    .res       (res_o)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the Di Zenzo color gradient block.
// Depends on cgdz_pkg, the cgdz stream interfaces and color_gradient_di_zenzo.
`timescale 1ns / 1ps
module tb;
  import cgdz_pkg::*;

  localparam int LINE_MAX   = 2048;
  localparam int STALL_MAX  = 3000;   // cycles without any beat before giving up
  localparam int HOLD_LEN   = 400;    // long receiver hold-off
  localparam int SETTLE_LEN = 200;    // a few interior results' worth of back-end time

  typedef struct {
    logic [MAGW-1:0] mag;
    logic            dir;
    logic            last;
  } grad_res_t;

  // One row of the directed stimulus. Where known is set, the expected result
  // is typed in; otherwise the predictor decides.
  typedef struct {
    logic       fs;
    logic [7:0] lum;
    logic [7:0] ca;
    logic [7:0] cb;
    logic       known;
    grad_res_t  res;
  } pix_row_t;

  logic clk_i;
  logic rst_ni;
  logic            cfg_we_i;
  logic [CFGIW-1:0] cfg_idx_i;
  logic [CFGW-1:0]  cfg_data_i;

  cgdz_pix_if pix ();
  cgdz_res_if res ();

  color_gradient_di_zenzo dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  // Predictor state: its own copy of the registers, line stores, window and
  // raster position.
  logic [23:0] up_ln [LINE_MAX];
  logic [23:0] mid_ln [LINE_MAX];
  logic [23:0] win [6];
  int unsigned reg_width;
  int unsigned reg_height;
  int unsigned col_n;
  int unsigned row_n;

  grad_res_t grad_q[$];
  int        err_cnt;
  bit        idle_on;
  bit        hold_req;
  int        quiet_cnt;

  pix_row_t dir_tab [27];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int chan_of(input logic [23:0] p, input int k);
    return int'(p[8*k +: 8]);
  endfunction

  // Largest m in 0..2047 with sqrt(V) >= m - 1/2, where 2V = s + sqrt(d).
  // This is round-half-up of the magnitude, done with integers only.
  function automatic int di_zenzo_round(input longint s, input longint d);
    longint lo, hi, m, u;
    lo = 0;
    hi = 2047;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      u = (2 * m - 1) * (2 * m - 1) - 2 * s;
      if (u <= 0 || 4 * d >= u * u) lo = m;
      else hi = m - 1;
    end
    return int'(lo);
  endfunction

  // Advances the raster model by one accepted pixel and queues the gradient
  // that the block owes for it, if the window center is interior.
  task automatic predict_gradient(input logic fs, input logic [23:0] px,
                                  input bit use_given, input grad_res_t given);
    int unsigned w, h, c;
    logic [23:0] tp [3];
    logic [23:0] md [3];
    logic [23:0] bt [3];
    longint gxx, gyy, gxy, dd;
    int gx, gy;
    grad_res_t r;
    w = clamp_u(reg_width, 3, LINE_MAX);
    h = clamp_u(reg_height, 3, FH_MAX);
    if (fs) begin
      col_n = 0;
      row_n = 0;
    end
    c = (col_n >= LINE_MAX) ? LINE_MAX - 1 : col_n;
    tp[0] = win[0]; md[0] = win[1]; bt[0] = win[2];
    tp[1] = win[3]; md[1] = win[4]; bt[1] = win[5];
    tp[2] = up_ln[c]; md[2] = mid_ln[c]; bt[2] = px;
    if (row_n >= 2 && col_n >= 2) begin
      gxx = 0;
      gyy = 0;
      gxy = 0;
      for (int k = 0; k < 3; k++) begin
        gx = chan_of(tp[2], k) + chan_of(md[2], k) + chan_of(bt[2], k)
           - chan_of(tp[0], k) - chan_of(md[0], k) - chan_of(bt[0], k);
        gy = chan_of(bt[0], k) + chan_of(bt[1], k) + chan_of(bt[2], k)
           - chan_of(tp[0], k) - chan_of(tp[1], k) - chan_of(tp[2], k);
        gxx += longint'(gx) * gx;
        gyy += longint'(gy) * gy;
        gxy += longint'(gx) * gy;
      end
      dd = gxx - gyy;
      r.mag  = MAGW'(di_zenzo_round(gxx + gyy, dd * dd + 4 * gxy * gxy));
      r.dir  = (gxx > gyy || (gxx == gyy && gxy == 0)) ? 1'b0 : 1'b1;
      r.last = (row_n == h - 1 && col_n == w - 1);
      grad_q.insert(grad_q.size(), use_given ? given : r);
    end
    win[0] = tp[1]; win[1] = md[1]; win[2] = bt[1];
    win[3] = tp[2]; win[4] = md[2]; win[5] = bt[2];
    up_ln[c]  = mid_ln[c];
    mid_ln[c] = px;
    if (col_n + 1 >= w) begin
      col_n = 0;
      row_n = (row_n + 1 >= h) ? 0 : row_n + 1;
    end else begin
      col_n++;
    end
  endtask

  // Offers one pixel beat, waits for it to be taken, then maybe leaves a gap.
  // valid stays high between back-to-back beats.
  task automatic send_pixel(input logic fs, input logic [7:0] l, input logic [7:0] a,
                            input logic [7:0] b, input bit use_given,
                            input grad_res_t given);
    pix.valid       <= 1'b1;
    pix.frame_start <= fs;
    pix.lum         <= l;
    pix.chroma_a    <= a;
    pix.chroma_b    <= b;
    do @(posedge clk_i); while (!pix.ready);
    predict_gradient(fs, {b, a, l}, use_given, given);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Writes both geometry registers once the block has gone quiet. The pixel
  // side is dropped first so that the last beat is not offered again.
  task automatic set_geometry(input int unsigned w, input int unsigned h);
    pix.valid <= 1'b0;
    wait (grad_q.size() == 0);
    repeat (SETTLE_LEN) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LINE_WIDTH;
    cfg_data_i <= CFGW'(w);
    @(posedge clk_i);
    reg_width  = w & 12'hFFF;
    cfg_idx_i  <= REG_FRAME_HEIGHT;
    cfg_data_i <= CFGW'(h);
    @(posedge clk_i);
    reg_height = h & 13'h1FFF;
    cfg_we_i   <= 1'b0;
  endtask

  // Random pixel with a mix of full-range noise, flat areas and saturated
  // values, so that equal gxx/gyy and the extreme magnitudes both come up.
  function automatic logic [7:0] rand_sample(input int mode, input logic [7:0] base);
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return base + 8'($urandom_range(0, 2));
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // A random phase of n beats in well-formed frames; a few beats carry a
  // stray frame start that restarts the raster in the middle of a frame.
  task automatic run_frames(input int n, input int unsigned w, input int unsigned h,
                            input int hold_at);
    int unsigned fsz;
    int mode;
    logic fs;
    logic [7:0] base;
    grad_res_t none;
    none = '{default: '0};
    fsz = clamp_u(w & 12'hFFF, 3, LINE_MAX) * clamp_u(h & 13'h1FFF, 3, FH_MAX);
    mode = 0;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      fs = (i % fsz == 0) || (i > 0 && $urandom_range(0, 99) == 0);
      if ($urandom_range(0, 15) == 0) begin
        mode = $urandom_range(0, 2);
        base = 8'($urandom_range(0, 255));
      end
      send_pixel(fs, rand_sample(mode, base), rand_sample(mode, base),
                 rand_sample(mode, base), 1'b0, none);
    end
  endtask

  // Result side: random ready bursts, plus the long hold-off when asked.
  initial begin
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Compares each result beat with the oldest expected gradient.
  always @(posedge clk_i) begin
    grad_res_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (grad_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result mag=%0d", res.magnitude));
      end else begin
        e = grad_q.pop_front();
        if (res.magnitude !== e.mag)
          report_mismatch($sformatf("magnitude %0d, want %0d", res.magnitude, e.mag));
        if (res.direction !== e.dir)
          report_mismatch($sformatf("direction %0b, want %0b", res.direction, e.dir));
        if (res.last_of_frame !== e.last)
          report_mismatch($sformatf("last_of_frame %0b, want %0b",
                                    res.last_of_frame, e.last));
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_MAX) begin
      $display("timeout after %0d quiet cycles", quiet_cnt);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    grad_res_t none;
    none = '{default: '0};
    err_cnt   = 0;
    quiet_cnt = 0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    reg_width  = 640;
    reg_height = 480;
    col_n = 0;
    row_n = 0;
    foreach (up_ln[i]) begin
      up_ln[i]  = '0;
      mid_ln[i] = '0;
    end
    foreach (win[i]) win[i] = '0;

    // Directed table: three 3x3 frames. A flat frame gives zero magnitude and
    // the vertical direction by the tie rule. A bright right column on the
    // lightness channel only gives 3*255 along x. A bright bottom row on all
    // three channels gives 765*sqrt(3), rounded to 1325, horizontal.
    for (int p = 0; p < 27; p++) begin
      int f, r, c;
      f = p / 9;
      r = (p % 9) / 3;
      c = p % 3;
      dir_tab[p].fs    = (p % 9 == 0);
      dir_tab[p].known = (p % 9 == 8);
      case (f)
        0: begin
          dir_tab[p].lum = 8'd128; dir_tab[p].ca = 8'd128; dir_tab[p].cb = 8'd128;
          dir_tab[p].res = '{mag: 11'd0, dir: 1'b0, last: 1'b1};
        end
        1: begin
          dir_tab[p].lum = (c == 2) ? 8'hFF : 8'h00;
          dir_tab[p].ca  = 8'h00;
          dir_tab[p].cb  = 8'h00;
          dir_tab[p].res = '{mag: 11'd765, dir: 1'b0, last: 1'b1};
        end
        default: begin
          dir_tab[p].lum = (r == 2) ? 8'hFF : 8'h00;
          dir_tab[p].ca  = dir_tab[p].lum;
          dir_tab[p].cb  = dir_tab[p].lum;
          dir_tab[p].res = '{mag: 11'd1325, dir: 1'b1, last: 1'b1};
        end
      endcase
    end

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_LINE_WIDTH;
    cfg_data_i      <= '0;
    pix.valid       <= 1'b0;
    pix.frame_start <= 1'b0;
    pix.lum         <= '0;
    pix.chroma_a    <= '0;
    pix.chroma_b    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_geometry(3, 3);
    foreach (dir_tab[i])
      send_pixel(dir_tab[i].fs, dir_tab[i].lum, dir_tab[i].ca, dir_tab[i].cb,
                 dir_tab[i].known, dir_tab[i].res);

    // Random phases. Each geometry change waits for the results to drain,
    // which also covers the sender pausing until nothing is outstanding.
    // Out-of-range values check the clamping to 3 and to the maximum sizes.
    run_frames(60, 3, 3, 12);
    set_geometry(0, 0);
    run_frames(60, 0, 0, -1);
    set_geometry(5, 4);
    run_frames(60, 5, 4, -1);
    set_geometry(17, 6);
    run_frames(110, 17, 6, 40);
    set_geometry(4095, 3);
    run_frames(40, 4095, 3, -1);
    set_geometry(4, 8191);
    run_frames(80, 4, 8191, -1);
    set_geometry(2048, 4096);
    run_frames(40, 2048, 4096, -1);
    set_geometry(9, 13);
    run_frames(120, 9, 13, -1);

    // Last stretch at full rate on both sides.
    set_geometry(6, 5);
    idle_on = 1'b0;
    run_frames(90, 6, 5, -1);
    pix.valid <= 1'b0;

    wait (grad_q.size() == 0);
    repeat (SETTLE_LEN) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
